### rtl/core/lltok_pkg.sv
// Shared types and constants for the lambda language tokenizer.
// Holds token kinds, character codes, keyword patterns and result queue sizing.
// No dependencies.
package lltok_pkg;

   // Token kinds as seen on the result channel
   typedef enum logic [3:0] {
      TK_LPAREN = 4'd0,
      TK_RPAREN = 4'd1,
      TK_DOT    = 4'd2,
      TK_EQUALS = 4'd3,
      TK_LAMBDA = 4'd4,
      TK_INT    = 4'd5,
      TK_IDENT  = 4'd6,
      TK_LET    = 4'd7,
      TK_IN     = 4'd8,
      TK_TRUE   = 4'd9,
      TK_FALSE  = 4'd10,
      TK_UNIT   = 4'd11,
      TK_EOF    = 4'd12,
      TK_ERROR  = 4'd13
   } tok_kind_type;

   // Scanner modes
   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_NUMBER  = 5'b00010,
      MODE_IDENT   = 5'b00100,
      MODE_COMMENT = 5'b01000,
      MODE_HALT    = 5'b10000
   } scan_mode_type;

   // Character codes
   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_EQUALS     = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

   // Keyword buffer holds the first five identifier bytes, last byte lowest
   localparam int          KW_BYTES   = 5;
   localparam int          KW_WIDTH   = 8 * KW_BYTES;
   localparam logic [KW_WIDTH-1:0] KW_LET   = 40'h00_006C_6574;
   localparam logic [KW_WIDTH-1:0] KW_IN    = 40'h00_0000_696E;
   localparam logic [KW_WIDTH-1:0] KW_TRUE  = 40'h00_7472_7565;
   localparam logic [KW_WIDTH-1:0] KW_FALSE = 40'h66_616C_7365;
   localparam logic [KW_WIDTH-1:0] KW_UNIT  = 40'h00_756E_6974;

   // Result queue sizing; one byte can produce two tokens
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Default widths
   localparam int DEF_POSITION_WIDTH = 16;
   localparam int DEF_INT_WIDTH      = 32;

endpackage

### rtl/core/lambda_language_tokenizer.sv
// Lambda language tokenizer: top level, byte scanner and result queue.
// Depends on lltok_pkg.
//
// Takes one source byte per cycle while req_stall is low and emits tokens on
// the rsp_ channel. Every byte is scanned in the cycle it is accepted; the
// tokens it produces (at most two: a pending int or identifier that the byte
// ends, then the byte's own token) are written into a four-entry result queue
// and leave one per cycle while rsp_stall is low. req_stall rises while the
// queue holds more than two tokens, so a byte is taken every cycle as long as
// the consumer keeps up with one token per cycle; a stream of bytes that each
// make two tokens runs at the output rate of one token per cycle. With an
// empty queue the first token of a byte appears on rsp_ the cycle after the
// byte transfer. After an eof or error token all input is dropped until reset.
module lambda_language_tokenizer #(
   parameter int POSITION_WIDTH = lltok_pkg::DEF_POSITION_WIDTH,
   parameter int INT_WIDTH      = lltok_pkg::DEF_INT_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // source byte channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_source_byte,
   input  logic                      req_end_of_input,
   // token channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [3:0]                rsp_token_kind,
   output logic [INT_WIDTH-1:0]      rsp_int_value,
   output logic [POSITION_WIDTH-1:0] rsp_ident_start,
   output logic [POSITION_WIDTH-1:0] rsp_ident_length,
   output logic [POSITION_WIDTH-1:0] rsp_token_line,
   output logic [POSITION_WIDTH-1:0] rsp_token_column,
   output logic                      rsp_last_of_run
);
   import lltok_pkg::*;

   typedef struct packed {
      tok_kind_type              kind;
      logic [INT_WIDTH-1:0]      int_value;
      logic [POSITION_WIDTH-1:0] ident_start;
      logic [POSITION_WIDTH-1:0] ident_length;
      logic [POSITION_WIDTH-1:0] line;
      logic [POSITION_WIDTH-1:0] column;
      logic                      last;
   } token_type;

   localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

   function automatic logic [POSITION_WIDTH-1:0] sat_inc(
      input logic [POSITION_WIDTH-1:0] v);
      return (&v) ? v : v + POS_ONE;
   endfunction

   // Scanner state
   scan_mode_type             mode_ff, mode_in;
   logic [INT_WIDTH-1:0]      acc_ff, acc_in;
   logic [POSITION_WIDTH-1:0] len_ff, len_in;
   logic [KW_WIDTH-1:0]       kw_ff, kw_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [POSITION_WIDTH-1:0] line_ff, line_in;
   logic [POSITION_WIDTH-1:0] col_ff, col_in;
   logic [POSITION_WIDTH-1:0] start_pos_ff, start_pos_in;
   logic [POSITION_WIDTH-1:0] start_line_ff, start_line_in;
   logic [POSITION_WIDTH-1:0] start_col_ff, start_col_in;

   // Result queue
   token_type                 queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    head_ff, head_in;
   logic [QUEUE_PTR_W-1:0]    tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;

   logic                      req_xfer;
   logic                      rsp_xfer;

   // Byte classification
   logic [7:0] c;
   logic       src_end;
   logic       is_digit;
   logic       is_alpha;
   logic       is_ident_char;
   logic       is_space;
   logic       is_single;
   tok_kind_type single_kind;
   tok_kind_type kw_kind;

   // Tokens produced by the current byte
   token_type flush_tok;
   logic      flush_valid;
   token_type new_tok;
   logic      new_valid;
   token_type slot0;
   token_type slot1;
   logic [1:0] push_count;

   assign req_stall = count_ff > QUEUE_CNT_W'(QUEUE_DEPTH - 2);
   assign req_xfer  = req_valid & ~req_stall;
   assign rsp_valid = count_ff != '0;
   assign rsp_xfer  = rsp_valid & ~rsp_stall;

   // Classify the incoming byte
   assign c        = req_source_byte;
   assign src_end  = req_end_of_input | (c == CHAR_NUL);
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign is_alpha = ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
                     ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
   assign is_ident_char = is_alpha || is_digit || (c == CHAR_UNDERSCORE) ||
                          (c == CHAR_APOSTROPHE);
   assign is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));

   always_comb begin
      is_single   = 1'b1;
      single_kind = TK_LAMBDA;
      case (c)
         CHAR_LPAREN:    single_kind = TK_LPAREN;
         CHAR_RPAREN:    single_kind = TK_RPAREN;
         CHAR_DOT:       single_kind = TK_DOT;
         CHAR_EQUALS:    single_kind = TK_EQUALS;
         CHAR_BACKSLASH: single_kind = TK_LAMBDA;
         default:        is_single = 1'b0;
      endcase
   end

   // Match the buffered identifier against the keywords
   always_comb begin
      kw_kind = TK_IDENT;
      if (len_ff == POSITION_WIDTH'(3) && kw_ff == KW_LET) begin
         kw_kind = TK_LET;
      end else if (len_ff == POSITION_WIDTH'(2) && kw_ff == KW_IN) begin
         kw_kind = TK_IN;
      end else if (len_ff == POSITION_WIDTH'(4) && kw_ff == KW_TRUE) begin
         kw_kind = TK_TRUE;
      end else if (len_ff == POSITION_WIDTH'(5) && kw_ff == KW_FALSE) begin
         kw_kind = TK_FALSE;
      end else if (len_ff == POSITION_WIDTH'(4) && kw_ff == KW_UNIT) begin
         kw_kind = TK_UNIT;
      end
   end

   // Scan one byte: next state and up to two tokens
   always_comb begin
      mode_in       = mode_ff;
      acc_in        = acc_ff;
      len_in        = len_ff;
      kw_in         = kw_ff;
      pos_in        = pos_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      start_pos_in  = start_pos_ff;
      start_line_in = start_line_ff;
      start_col_in  = start_col_ff;

      flush_valid        = 1'b0;
      flush_tok          = '0;
      flush_tok.kind     = TK_INT;
      flush_tok.line     = start_line_ff;
      flush_tok.column   = start_col_ff;
      new_valid          = 1'b0;
      new_tok            = '0;
      new_tok.kind       = TK_EOF;
      new_tok.line       = line_ff;
      new_tok.column     = col_ff;

      if (req_xfer) begin
         unique case (mode_ff)
            MODE_HALT: begin
               // drop everything until reset
            end
            MODE_COMMENT: begin
               if (src_end) begin
                  new_valid = 1'b1;
                  mode_in   = MODE_HALT;
               end else if (c == CHAR_NEWLINE) begin
                  mode_in = MODE_IDLE;
                  pos_in  = sat_inc(pos_ff);
                  line_in = sat_inc(line_ff);
                  col_in  = POS_ONE;
               end else begin
                  pos_in = sat_inc(pos_ff);
               end
            end
            default: begin
               if (!src_end && mode_ff == MODE_NUMBER && is_digit) begin
                  // extend the integer: acc * 10 + digit
                  acc_in = (acc_ff << 3) + (acc_ff << 1) + INT_WIDTH'(c[3:0]);
                  pos_in = sat_inc(pos_ff);
                  col_in = sat_inc(col_ff);
               end else if (!src_end && mode_ff == MODE_IDENT && is_ident_char) begin
                  // extend the identifier
                  if (len_ff < POSITION_WIDTH'(KW_BYTES)) begin
                     kw_in = {kw_ff[KW_WIDTH-9:0], c};
                  end
                  len_in = sat_inc(len_ff);
                  pos_in = sat_inc(pos_ff);
                  col_in = sat_inc(col_ff);
               end else begin
                  // flush a pending int or identifier
                  if (mode_ff == MODE_NUMBER) begin
                     flush_valid         = 1'b1;
                     flush_tok.kind      = TK_INT;
                     flush_tok.int_value = acc_ff;
                  end else if (mode_ff == MODE_IDENT) begin
                     flush_valid    = 1'b1;
                     flush_tok.kind = kw_kind;
                     if (kw_kind == TK_IDENT) begin
                        flush_tok.ident_start  = start_pos_ff;
                        flush_tok.ident_length = len_ff;
                     end
                  end
                  mode_in = MODE_IDLE;

                  // handle the byte itself
                  if (src_end) begin
                     new_valid = 1'b1;
                     mode_in   = MODE_HALT;
                  end else if (c == CHAR_NEWLINE) begin
                     pos_in  = sat_inc(pos_ff);
                     line_in = sat_inc(line_ff);
                     col_in  = POS_ONE;
                  end else if (is_space) begin
                     pos_in = sat_inc(pos_ff);
                     col_in = sat_inc(col_ff);
                  end else if (c == CHAR_HASH) begin
                     mode_in = MODE_COMMENT;
                     pos_in  = sat_inc(pos_ff);
                  end else if (is_single) begin
                     new_valid    = 1'b1;
                     new_tok.kind = single_kind;
                     pos_in       = sat_inc(pos_ff);
                     col_in       = sat_inc(col_ff);
                  end else if (is_digit || is_alpha || c == CHAR_UNDERSCORE) begin
                     start_pos_in  = pos_ff;
                     start_line_in = line_ff;
                     start_col_in  = col_ff;
                     if (is_digit) begin
                        mode_in = MODE_NUMBER;
                        acc_in  = INT_WIDTH'(c[3:0]);
                     end else begin
                        mode_in = MODE_IDENT;
                        len_in  = POS_ONE;
                        kw_in   = KW_WIDTH'(c);
                     end
                     pos_in = sat_inc(pos_ff);
                     col_in = sat_inc(col_ff);
                  end else begin
                     new_valid    = 1'b1;
                     new_tok.kind = TK_ERROR;
                     mode_in      = MODE_HALT;
                  end
               end
            end
         endcase
      end
   end

   // Pack the tokens into queue slots, marking the last of the run
   always_comb begin
      slot0      = flush_valid ? flush_tok : new_tok;
      slot0.last = ~(flush_valid & new_valid);
      slot1      = new_tok;
      slot1.last = 1'b1;
      push_count = {1'b0, flush_valid} + {1'b0, new_valid};
   end

   // Advance queue pointers and fill level
   always_comb begin
      tail_in  = tail_ff + QUEUE_PTR_W'(push_count);
      head_in  = rsp_xfer ? head_ff + QUEUE_PTR_W'(1) : head_ff;
      count_in = count_ff + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(rsp_xfer);
   end

   // Scanner and queue control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         acc_ff        <= '0;
         len_ff        <= '0;
         kw_ff         <= '0;
         pos_ff        <= '0;
         line_ff       <= POS_ONE;
         col_ff        <= POS_ONE;
         start_pos_ff  <= '0;
         start_line_ff <= POS_ONE;
         start_col_ff  <= POS_ONE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
      end else begin
         mode_ff       <= mode_in;
         acc_ff        <= acc_in;
         len_ff        <= len_in;
         kw_ff         <= kw_in;
         pos_ff        <= pos_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         start_pos_ff  <= start_pos_in;
         start_line_ff <= start_line_in;
         start_col_ff  <= start_col_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
      end
   end

   // Write produced tokens into the queue
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[tail_ff] <= slot0;
      end
      if (push_count == 2'd2) begin
         queue_ff[tail_ff + QUEUE_PTR_W'(1)] <= slot1;
      end
   end

   // Drive the head token
   assign rsp_token_kind   = queue_ff[head_ff].kind;
   assign rsp_int_value    = queue_ff[head_ff].int_value;
   assign rsp_ident_start  = queue_ff[head_ff].ident_start;
   assign rsp_ident_length = queue_ff[head_ff].ident_length;
   assign rsp_token_line   = queue_ff[head_ff].line;
   assign rsp_token_column = queue_ff[head_ff].column;
   assign rsp_last_of_run  = queue_ff[head_ff].last;

endmodule
